// ----- design/gha_pkg.sv -----
// ----------------------------------------------------------------------------
// gha_pkg
// Shared constants and codes of the generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

    // Port field widths
    localparam int IDX_PORT_W = 10;
    localparam int GEN_PORT_W = 12;
    localparam int CNT_PORT_W = 11;

    // Default sizing of the allocator
    localparam int DEF_MAX_ENTRIES = 1024;
    localparam int DEF_GEN_BITS    = 12;

    // Request codes
    localparam logic [1:0] MODE_SPAWN   = 2'd0;
    localparam logic [1:0] MODE_DESTROY = 2'd1;
    localparam logic [1:0] MODE_QUERY   = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_DEAD = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

endpackage

// ----- design/gha_ram.sv -----
// ----------------------------------------------------------------------------
// gha_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gha_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 13,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write the array and register the read data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- design/generational_handle_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// generational_handle_allocator_unit
// Handle allocator with per-entry generation counters and a LIFO of retired
// indexes.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with mode and a handle while busy is low; the item is taken
//   at that clock edge. Spawn pops the most recently retired index, or takes
//   the next fresh index at generation 0, or reports full. Destroy retires a
//   live handle and advances its generation. Query checks a handle.
//   The entry table and the retired stack are synchronous RAMs with a
//   registered read. The accept cycle issues both RAM reads; the busy
//   cycle evaluates the item and writes back; the result is on the outputs
//   in the cycle after, marked by done for exactly one cycle. Each item is
//   a read then a write of the RAMs; a new item may be started in the same
//   cycle its predecessor's result is shown. The receiver cannot stall.
//   Each retired stack slot holds the index and its current generation, so
//   a pop needs a single read. Reads and writes never share a cycle, so no
//   forwarding is needed. Reset clears state and counters only; RAM contents
//   are reached only below the fill and stack counts, so no clearing pass runs.
// ----------------------------------------------------------------------------
module generational_handle_allocator_unit
    import gha_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int GEN_BITS    = DEF_GEN_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            mode,
    input  logic                  handle_is_valid,
    input  logic [IDX_PORT_W-1:0] entity_index,
    input  logic [GEN_PORT_W-1:0] entity_generation,
    output logic                  done,
    output logic [1:0]            status,
    output logic [IDX_PORT_W-1:0] out_index,
    output logic [GEN_PORT_W-1:0] out_generation,
    output logic [CNT_PORT_W-1:0] live_count
);

    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > IDX_PORT_W) ? CNT_W : IDX_PORT_W;
    localparam int GCMP_W = (GEN_BITS > GEN_PORT_W) ? GEN_BITS : GEN_PORT_W;
    localparam int ENT_W  = GEN_BITS + 1;
    localparam int STK_W  = IDX_W + GEN_BITS;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0] depth_reg, depth_next;
    logic [CNT_W-1:0] alive_reg, alive_next;
    logic             done_reg, done_next;

    logic [1:0]            mode_reg;
    logic                  valid_reg;
    logic [IDX_PORT_W-1:0] idx_reg;
    logic [GEN_PORT_W-1:0] gen_reg;

    logic [1:0]            status_reg, status_next;
    logic [IDX_PORT_W-1:0] oidx_reg, oidx_next;
    logic [GEN_PORT_W-1:0] ogen_reg, ogen_next;

    logic             accept;
    logic             ent_we, stk_we;
    logic [IDX_W-1:0] ent_waddr, stk_waddr;
    logic [ENT_W-1:0] ent_wdata, ent_rdata;
    logic [STK_W-1:0] stk_wdata, stk_rdata;

    logic                in_range;
    logic                alive_hit;
    logic [GEN_BITS-1:0] rd_gen;
    logic [GEN_BITS-1:0] bump_gen;
    logic [IDX_W-1:0]    pop_idx;
    logic [GEN_BITS-1:0] pop_gen;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg == ST_EXEC);

    // Entry table: {generation, alive}
    gha_ram #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (ENT_W)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .re    (accept),
        .raddr (IDX_W'(entity_index)),
        .rdata (ent_rdata)
    );

    // Retired stack: {index, generation}
    gha_ram #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (STK_W)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (accept),
        .raddr (IDX_W'(depth_reg - CNT_W'(1))),
        .rdata (stk_rdata)
    );

    // Decode read data
    assign rd_gen   = ent_rdata[GEN_BITS:1];
    assign bump_gen = rd_gen + GEN_BITS'(1);
    assign pop_idx  = stk_rdata[STK_W-1:GEN_BITS];
    assign pop_gen  = stk_rdata[GEN_BITS-1:0];
    assign in_range = valid_reg && (CMP_W'(idx_reg) < CMP_W'(used_reg));
    assign alive_hit = in_range && ent_rdata[0]
                       && (GCMP_W'(rd_gen) == GCMP_W'(gen_reg));

    // Evaluate the item and build write-back
    always_comb
    begin
        state_next  = state_reg;
        used_next   = used_reg;
        depth_next  = depth_reg;
        alive_next  = alive_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        oidx_next   = oidx_reg;
        ogen_next   = ogen_reg;
        ent_we      = 1'b0;
        ent_waddr   = IDX_W'(idx_reg);
        ent_wdata   = {bump_gen, 1'b0};
        stk_we      = 1'b0;
        stk_waddr   = IDX_W'(depth_reg);
        stk_wdata   = {IDX_W'(idx_reg), bump_gen};

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next  = ST_IDLE;
                done_next   = 1'b1;
                status_next = STATUS_DEAD;
                oidx_next   = idx_reg;
                ogen_next   = gen_reg;
                case (mode_reg)
                    MODE_SPAWN:
                    begin
                        if (depth_reg != '0)
                        begin
                            ent_we      = 1'b1;
                            ent_waddr   = pop_idx;
                            ent_wdata   = {pop_gen, 1'b1};
                            depth_next  = depth_reg - CNT_W'(1);
                            alive_next  = alive_reg + CNT_W'(1);
                            status_next = STATUS_OK;
                            oidx_next   = IDX_PORT_W'(pop_idx);
                            ogen_next   = GEN_PORT_W'(pop_gen);
                        end
                        else if (used_reg < CNT_W'(MAX_ENTRIES))
                        begin
                            ent_we      = 1'b1;
                            ent_waddr   = IDX_W'(used_reg);
                            ent_wdata   = {{GEN_BITS{1'b0}}, 1'b1};
                            used_next   = used_reg + CNT_W'(1);
                            alive_next  = alive_reg + CNT_W'(1);
                            status_next = STATUS_OK;
                            oidx_next   = IDX_PORT_W'(used_reg);
                            ogen_next   = '0;
                        end
                        else
                        begin
                            status_next = STATUS_FULL;
                            oidx_next   = '0;
                            ogen_next   = '0;
                        end
                    end
                    MODE_DESTROY:
                    begin
                        if (alive_hit)
                        begin
                            ent_we      = 1'b1;
                            status_next = STATUS_OK;
                            if (depth_reg < CNT_W'(MAX_ENTRIES))
                            begin
                                stk_we     = 1'b1;
                                depth_next = depth_reg + CNT_W'(1);
                            end
                            if (alive_reg != '0)
                            begin
                                alive_next = alive_reg - CNT_W'(1);
                            end
                        end
                    end
                    MODE_QUERY:
                    begin
                        status_next = alive_hit ? STATUS_OK : STATUS_DEAD;
                    end
                    default:
                    begin
                        status_next = STATUS_DEAD;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            used_reg  <= '0;
            depth_reg <= '0;
            alive_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            depth_reg <= depth_next;
            alive_reg <= alive_next;
            done_reg  <= done_next;
        end
    end

    // Capture the item and the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= mode;
            valid_reg <= handle_is_valid;
            idx_reg   <= entity_index;
            gen_reg   <= entity_generation;
        end
        status_reg <= status_next;
        oidx_reg   <= oidx_next;
        ogen_reg   <= ogen_next;
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign out_index      = oidx_reg;
    assign out_generation = ogen_reg;
    assign live_count     = CNT_PORT_W'(alive_reg);

    // Every used entry is either alive or on the retired stack
    a_count_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W + 1)'(depth_reg) + (CNT_W + 1)'(alive_reg) == (CNT_W + 1)'(used_reg))
        else $error("alive and retired counts do not add up to used entries");

    // A result follows an evaluate cycle
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_EXEC))
        else $error("result strobe without an evaluated item");

    // An accepted item enters the evaluate state, with done low there
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy && done_reg == 1'b0)
        else $error("item accepted without entering evaluate");

    // Full is reported only when the table is exhausted
    a_full_only_exhausted: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == STATUS_FULL) |->
            (used_reg == CNT_W'(MAX_ENTRIES) && depth_reg == '0))
        else $error("full reported with free entries");

endmodule

// ----- test/gha_checker.sv -----
// ----------------------------------------------------------------------------
// gha_checker
// Watches the request and result channels of the handle allocator, keeps its
// own copy of the entry table, retired stack and live count, and compares
// every result field against the answer predicted for the oldest request.
// ----------------------------------------------------------------------------
module gha_checker
    import gha_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [1:0]            mode,
    input  logic                  handle_is_valid,
    input  logic [IDX_PORT_W-1:0] entity_index,
    input  logic [GEN_PORT_W-1:0] entity_generation,
    input  logic                  done,
    input  logic [1:0]            status,
    input  logic [IDX_PORT_W-1:0] out_index,
    input  logic [GEN_PORT_W-1:0] out_generation,
    input  logic [CNT_PORT_W-1:0] live_count,
    output int                    mismatches,
    output int                    pending,
    output int                    results_seen,
    output int                    full_answers,
    output int                    gen_wraps
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES = DEF_MAX_ENTRIES;
    localparam logic [GEN_PORT_W-1:0] GEN_MASK =
        GEN_PORT_W'((64'd1 << DEF_GEN_BITS) - 1);

    typedef struct packed {
        logic [1:0]            status;
        logic [IDX_PORT_W-1:0] idx;
        logic [GEN_PORT_W-1:0] gen;
        logic [CNT_PORT_W-1:0] count;
    } alloc_result_t;

    // Shadow allocator state
    logic [GEN_PORT_W-1:0] entry_gen   [ENTRIES];
    bit                    entry_live  [ENTRIES];
    logic [IDX_PORT_W-1:0] retired_idx [ENTRIES];
    int                    fresh_used;
    int                    retired_top;
    int                    live_total;

    alloc_result_t answers_due[$];

    // Check whether a handle names a live entry of the same generation
    function automatic bit names_live(logic valid, logic [IDX_PORT_W-1:0] idx,
                                      logic [GEN_PORT_W-1:0] gen);
        if (!valid || int'(idx) >= fresh_used)
            return 1'b0;
        return entry_live[idx] && entry_gen[idx] == gen;
    endfunction

    // Apply one request to the shadow state and return its answer
    function automatic alloc_result_t apply_request(logic [1:0] m, logic valid,
                                                    logic [IDX_PORT_W-1:0] idx,
                                                    logic [GEN_PORT_W-1:0] gen);
        alloc_result_t a;
        int e;
        a.status = STATUS_DEAD;
        a.idx    = idx;
        a.gen    = gen;
        case (m)
            MODE_SPAWN:
            begin
                if (retired_top > 0)
                begin
                    // reuse the most recently retired index
                    retired_top--;
                    e = retired_idx[retired_top];
                    entry_live[e] = 1'b1;
                    a.idx    = IDX_PORT_W'(e);
                    a.gen    = entry_gen[e];
                    a.status = STATUS_OK;
                    live_total++;
                end
                else if (fresh_used < ENTRIES)
                begin
                    e = fresh_used;
                    entry_gen[e]  = '0;
                    entry_live[e] = 1'b1;
                    fresh_used++;
                    a.idx    = IDX_PORT_W'(e);
                    a.gen    = '0;
                    a.status = STATUS_OK;
                    live_total++;
                end
                else
                begin
                    a.status = STATUS_FULL;
                    a.idx    = '0;
                    a.gen    = '0;
                    full_answers++;
                end
            end
            MODE_DESTROY:
            begin
                if (names_live(valid, idx, gen))
                begin
                    if (entry_gen[idx] == GEN_MASK)
                        gen_wraps++;
                    entry_gen[idx]  = (entry_gen[idx] + 1'b1) & GEN_MASK;
                    entry_live[idx] = 1'b0;
                    if (retired_top < ENTRIES)
                    begin
                        retired_idx[retired_top] = idx;
                        retired_top++;
                    end
                    if (live_total > 0)
                        live_total--;
                    a.status = STATUS_OK;
                end
            end
            MODE_QUERY:
                a.status = names_live(valid, idx, gen) ? STATUS_OK : STATUS_DEAD;
            default:
                ;
        endcase
        a.count = CNT_PORT_W'(live_total);
        return a;
    endfunction

    // Compare results first, then record the item taken at the same edge
    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t want;
        if (!rst_n)
        begin
            fresh_used   = 0;
            retired_top  = 0;
            live_total   = 0;
            mismatches   = 0;
            results_seen = 0;
            full_answers = 0;
            gen_wraps    = 0;
            answers_due.delete();
            pending      = 0;
        end
        else
        begin
            if (done)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("result with no item waiting: status %0d index %0d gen %0d",
                           status, out_index, out_generation);
                    mismatches++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    results_seen++;
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        mismatches++;
                    end
                    if (out_index !== want.idx)
                    begin
                        $error("out_index: expected %0d, got %0d", want.idx, out_index);
                        mismatches++;
                    end
                    if (out_generation !== want.gen)
                    begin
                        $error("out_generation: expected %0d, got %0d",
                               want.gen, out_generation);
                        mismatches++;
                    end
                    if (live_count !== want.count)
                    begin
                        $error("live_count: expected %0d, got %0d", want.count, live_count);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                answers_due.push_back(apply_request(mode, handle_is_valid,
                                                    entity_index, entity_generation));
            pending = answers_due.size();
        end
    end

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives spawn, destroy, query and unused-mode items into the handle allocator:
// a directed opening, a run of generation steps on one index, and random
// traffic built mostly from handles seen in earlier results. Items go out in
// bursts with random gaps; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module testbench
    import gha_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int POOL_SIZE    = 48;
    localparam int RANDOM_ITEMS = 850;
    localparam int GEN_ROUNDS   = 40;
    localparam longint TIMEOUT_NS = 64'd1_000_000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [1:0]            mode;
    logic                  handle_is_valid;
    logic [IDX_PORT_W-1:0] entity_index;
    logic [GEN_PORT_W-1:0] entity_generation;
    logic                  done;
    logic [1:0]            status;
    logic [IDX_PORT_W-1:0] out_index;
    logic [GEN_PORT_W-1:0] out_generation;
    logic [CNT_PORT_W-1:0] live_count;

    int mismatches;
    int pending;
    int results_seen;
    int full_answers;
    int gen_wraps;

    // Handles seen in successful results, used to build destroys and queries
    logic [IDX_PORT_W+GEN_PORT_W-1:0] handle_pool [POOL_SIZE];
    int pool_count = 0;
    int pool_wr    = 0;
    int burst_left = 0;

    generational_handle_allocator_unit i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .mode              (mode),
        .handle_is_valid   (handle_is_valid),
        .entity_index      (entity_index),
        .entity_generation (entity_generation),
        .done              (done),
        .status            (status),
        .out_index         (out_index),
        .out_generation    (out_generation),
        .live_count        (live_count)
    );

    gha_checker i_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .mode              (mode),
        .handle_is_valid   (handle_is_valid),
        .entity_index      (entity_index),
        .entity_generation (entity_generation),
        .done              (done),
        .status            (status),
        .out_index         (out_index),
        .out_generation    (out_generation),
        .live_count        (live_count),
        .mismatches        (mismatches),
        .pending           (pending),
        .results_seen      (results_seen),
        .full_answers      (full_answers),
        .gen_wraps         (gen_wraps)
    );

    always #6 clk = ~clk;

    // Remember handles from successful results
    always @(posedge clk)
    begin
        if (rst_n && done && status == STATUS_OK)
        begin
            handle_pool[pool_wr] = {out_index, out_generation};
            pool_wr = (pool_wr + 1) % POOL_SIZE;
            if (pool_count < POOL_SIZE)
                pool_count++;
        end
    end

    // Send one item; hold it until the block takes it
    task automatic issue(logic [1:0] m, logic valid, logic [IDX_PORT_W-1:0] idx,
                         logic [GEN_PORT_W-1:0] gen);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        start             <= 1'b1;
        mode              <= m;
        handle_is_valid   <= valid;
        entity_index      <= idx;
        entity_generation <= gen;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic spawn_item();
        issue(MODE_SPAWN, 1'($urandom_range(0, 1)), IDX_PORT_W'($urandom_range(0, 1023)),
              GEN_PORT_W'($urandom_range(0, 4095)));
    endtask

    // Pick a handle: mostly a recent one, sometimes aged or fully random
    task automatic pick_handle(output logic [IDX_PORT_W-1:0] idx,
                               output logic [GEN_PORT_W-1:0] gen);
        int k;
        if (pool_count == 0 || $urandom_range(0, 9) == 0)
        begin
            idx = IDX_PORT_W'($urandom_range(0, 1023));
            gen = GEN_PORT_W'($urandom_range(0, 4095));
        end
        else
        begin
            k = $urandom_range(0, pool_count - 1);
            {idx, gen} = handle_pool[k];
            if ($urandom_range(0, 7) == 0)
                gen = gen + 1'b1;
        end
    endtask

    task automatic random_item();
        int r;
        logic valid;
        logic [IDX_PORT_W-1:0] idx;
        logic [GEN_PORT_W-1:0] gen;
        r = $urandom_range(0, 99);
        pick_handle(idx, gen);
        valid = ($urandom_range(0, 19) != 0);
        if (r < 38)
            spawn_item();
        else if (r < 68)
            issue(MODE_DESTROY, valid, idx, gen);
        else if (r < 92)
            issue(MODE_QUERY, valid, idx, gen);
        else
            issue(MODE_UNUSED, 1'($urandom_range(0, 1)), IDX_PORT_W'($urandom_range(0, 1023)),
                  GEN_PORT_W'($urandom_range(0, 4095)));
    endtask

    // Stimulus
    initial
    begin
        logic [GEN_PORT_W-1:0] step_gen;
        start             = 1'b0;
        mode              = MODE_SPAWN;
        handle_is_valid   = 1'b0;
        entity_index      = '0;
        entity_generation = '0;
        rst_n             = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty table: out of range, null handle, unused mode, field extremes
        issue(MODE_QUERY,   1'b1, '0, '0);
        issue(MODE_DESTROY, 1'b0, '0, '0);
        issue(MODE_UNUSED,  1'b1, '1, '1);
        issue(MODE_QUERY,   1'b1, '1, '1);
        // Fresh spawns, then live, stale and null queries
        issue(MODE_SPAWN,   1'b1, '1, '1);
        issue(MODE_SPAWN,   1'b0, '0, '0);
        issue(MODE_QUERY,   1'b1, 10'd0, 12'd0);
        issue(MODE_QUERY,   1'b1, 10'd0, 12'd1);
        issue(MODE_QUERY,   1'b0, 10'd0, 12'd0);
        // Retire, stale destroy, reuse from the retired stack in LIFO order
        issue(MODE_DESTROY, 1'b1, 10'd1, 12'd0);
        issue(MODE_DESTROY, 1'b1, 10'd1, 12'd0);
        issue(MODE_QUERY,   1'b1, 10'd1, 12'd1);
        issue(MODE_SPAWN,   1'b1, 10'd5, 12'd5);
        issue(MODE_DESTROY, 1'b1, 10'd0, 12'd0);
        issue(MODE_DESTROY, 1'b1, 10'd1, 12'd1);
        issue(MODE_SPAWN,   1'b1, 10'd0, 12'd0);
        issue(MODE_SPAWN,   1'b1, 10'd0, 12'd0);
        issue(MODE_DESTROY, 1'b1, 10'd2, 12'd0);
        issue(MODE_UNUSED,  1'b0, '0, '0);

        // Step index 1 through a run of generations by retire and reuse
        step_gen = 12'd2;
        repeat (GEN_ROUNDS)
        begin
            issue(MODE_DESTROY, 1'b1, 10'd1, step_gen);
            spawn_item();
            step_gen = step_gen + 1'b1;
        end
        issue(MODE_QUERY, 1'b1, 10'd1, step_gen);

        // Random traffic
        repeat (RANDOM_ITEMS)
            random_item();

        // Drain and report
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        $display("Checked %0d results over directed cases, generation steps on one index",
                 results_seen);
        $display("and random traffic: %0d full answers, %0d wraps, %0d mismatches",
                 full_answers, gen_wraps, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Guard against a hung handshake
    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout with %0d results still due", pending);
        $display("Some tests failed");
        $finish;
    end

endmodule
